@@ design/i2cm_pkg.sv @@
package i2cm_pkg;

  localparam int MAX_BYTES_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RST  = 16'd5;
  localparam logic [7:0]  ACK_POLL_LIM_RST = 8'd100;
  localparam logic [15:0] SETTLE_TICKS_RST = 16'd2000;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_LOAD  = 2'd2
  } req_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'd0,
    S_ST_A     = 5'd1,
    S_ST_B     = 5'd2,
    S_ST_C     = 5'd3,
    S_TX_SET   = 5'd4,
    S_TX_HIGH  = 5'd5,
    S_TX_LOW   = 5'd6,
    S_ACK_REL  = 5'd7,
    S_ACK_HIGH = 5'd8,
    S_ACK_POLL = 5'd9,
    S_ACK_LOW  = 5'd10,
    S_RX_HIGH  = 5'd11,
    S_RX_LOW   = 5'd12,
    S_AO_SET   = 5'd13,
    S_AO_HIGH  = 5'd14,
    S_AO_LOW   = 5'd15,
    S_STOP_P   = 5'd16,
    S_STOP_A   = 5'd17,
    S_SETTLE   = 5'd18
  } seq_state_t;

  // which byte of the transfer the shifter is working on
  typedef enum logic [1:0] {
    SEG_ADDR_W  = 2'd0,
    SEG_SUBADDR = 2'd1,
    SEG_TXDATA  = 2'd2,
    SEG_ADDR_R  = 2'd3
  } seg_t;

  typedef struct packed {
    req_t       req_type;
    logic       sda_in;
    logic [6:0] slave_addr;
    logic [7:0] reg_addr;
    logic       is_read;
    logic [4:0] byte_count;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       ack_error;
  } out_item_t;

endpackage

@@ design/i2c_register_master.sv @@
// each accepted item's result is registered in the output register in the next cycle
// throughput: one item per clock; the input stalls only while a result waits
//   in the output register and the result side stalls
// reset (rst_n low, synchronous): bus released (scl and sda high), sequencer idle,
//   registers back to 5 / 100 / 2000; the write buffer is not cleared
module i2c_register_master
  import i2cm_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  // configuration registers
  logic [15:0] phase_ticks_r;
  logic [7:0]  ack_poll_limit_r;
  logic [15:0] settle_ticks_r;

  // sequencer state
  seq_state_t st_r, st_nxt;
  seg_t       seg_r, seg_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [CNT_W-1:0] byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [15:0] settle_r, settle_nxt;
  logic [CNT_W-1:0] load_ptr_r, load_ptr_nxt;
  logic [6:0]  slave_r, slave_nxt;
  logic [7:0]  regaddr_r, regaddr_nxt;
  logic        read_r, read_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        abort_r, abort_nxt;

  // write data buffer, read through a register ahead of use
  logic [7:0]       tx_mem [MAX_BYTES];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;

  logic accept;

  // derived values
  logic [15:0]      phase_load;
  logic [7:0]       poll_lim;
  logic [7:0]       poll_inc;
  logic [15:0]      settle_dec;
  logic [3:0]       bit_inc;
  logic [CNT_W-1:0] byte_inc;
  logic [7:0]       tx_shifted;
  logic [4:0]       cnt_fix;
  logic [CNT_W-1:0] cnt_sat;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // zero in the phase length or the ack poll limit behaves as one
  assign phase_load = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;
  assign poll_lim   = (ack_poll_limit_r == 8'd0) ? 8'd1 : ack_poll_limit_r;
  assign poll_inc   = poll_r + 8'd1;
  assign settle_dec = (settle_r != 16'd0) ? settle_r - 16'd1 : 16'd0;
  assign bit_inc    = bit_r + 4'd1;
  assign byte_inc   = byte_r + CNT_W'(1);
  assign tx_shifted = shift_r << bit_inc;

  // read count of zero moves one byte; counts saturate at the buffer depth
  assign cnt_fix = (in_data.is_read && in_data.byte_count == 5'd0) ? 5'd1
                                                                   : in_data.byte_count;
  assign cnt_sat = (int'(cnt_fix) > MAX_BYTES) ? CNT_W'(MAX_BYTES) : CNT_W'(cnt_fix);

  // next data byte address: the one after the current byte while sending data,
  // else the first entry (used when the subaddress ack ends)
  always_comb begin
    rd_addr = '0;
    if (seg_r == SEG_TXDATA && byte_inc < CNT_W'(MAX_BYTES)) begin
      rd_addr = byte_inc[IDX_W-1:0];
    end
  end

  assign mem_we = accept && in_data.req_type == REQ_LOAD && st_r == S_IDLE &&
                  load_ptr_r < CNT_W'(MAX_BYTES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[load_ptr_r[IDX_W-1:0]] <= in_data.tx_byte;
    end
    rd_data_r <= tx_mem[rd_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r    <= PHASE_TICKS_RST;
      ack_poll_limit_r <= ACK_POLL_LIM_RST;
      settle_ticks_r   <= SETTLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS:  phase_ticks_r    <= cfg_wdata;
        CFG_ACK_POLL_LIM: ack_poll_limit_r <= cfg_wdata[7:0];
        CFG_SETTLE_TICKS: settle_ticks_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: one step per accepted item
  always_comb begin
    st_nxt       = st_r;
    seg_nxt      = seg_r;
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    byte_nxt     = byte_r;
    shift_nxt    = shift_r;
    poll_nxt     = poll_r;
    settle_nxt   = settle_r;
    load_ptr_nxt = load_ptr_r;
    slave_nxt    = slave_r;
    regaddr_nxt  = regaddr_r;
    read_nxt     = read_r;
    count_nxt    = count_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    abort_nxt    = abort_r;
    res          = '0;

    case (in_data.req_type)
      REQ_TICK: begin
        if (st_r == S_SETTLE) begin
          // post-write settle wait
          settle_nxt = settle_dec;
          if (settle_dec == 16'd0) begin
            st_nxt       = S_IDLE;
            res.done_res = 1'b1;
            res.ack_error = abort_r;
          end
        end else if (st_r == S_ACK_POLL) begin
          // poll sda for the slave ack, once per tick
          if (!in_data.sda_in) begin
            st_nxt = S_ACK_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = phase_load;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= poll_lim) begin
              abort_nxt = 1'b1;
              st_nxt = S_STOP_P; scl_nxt = 1'b0; sda_nxt = 1'b0; phase_nxt = phase_load;
            end
          end
        end else if (st_r != S_IDLE && phase_r > 16'd1) begin
          phase_nxt = phase_r - 16'd1;
        end else if (st_r != S_IDLE) begin
          // slot over: move to the next bus phase
          phase_nxt = 16'd0;
          unique case (st_r)
            S_ST_A: begin
              st_nxt = S_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0; phase_nxt = phase_load;
            end
            S_ST_B: begin
              st_nxt = S_ST_C; scl_nxt = 1'b0; sda_nxt = 1'b0; phase_nxt = phase_load;
            end
            S_ST_C: begin
              bit_nxt = 4'd0;
              st_nxt = S_TX_SET; scl_nxt = 1'b0; sda_nxt = shift_r[7];
              phase_nxt = phase_load;
            end
            S_TX_SET: begin
              st_nxt = S_TX_HIGH; scl_nxt = 1'b1; phase_nxt = phase_load;
            end
            S_TX_HIGH: begin
              st_nxt = S_TX_LOW; scl_nxt = 1'b0; phase_nxt = phase_load;
            end
            S_TX_LOW: begin
              bit_nxt = bit_inc;
              if (bit_inc >= 4'd8) begin
                st_nxt = S_ACK_REL; scl_nxt = 1'b0; sda_nxt = 1'b1;
              end else begin
                st_nxt = S_TX_SET; scl_nxt = 1'b0; sda_nxt = tx_shifted[7];
              end
              phase_nxt = phase_load;
            end
            S_ACK_REL: begin
              st_nxt = S_ACK_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = phase_load;
            end
            S_ACK_HIGH: begin
              poll_nxt = 8'd0;
              st_nxt   = S_ACK_POLL;
            end
            S_ACK_LOW: begin
              phase_nxt = phase_load;
              unique case (seg_r)
                SEG_ADDR_W: begin
                  seg_nxt = SEG_SUBADDR;
                  shift_nxt = regaddr_r;
                  bit_nxt = 4'd0;
                  st_nxt = S_TX_SET; scl_nxt = 1'b0; sda_nxt = regaddr_r[7];
                end
                SEG_SUBADDR: begin
                  if (read_r) begin
                    // repeated start, then address with read bit
                    seg_nxt = SEG_ADDR_R;
                    shift_nxt = {slave_r, 1'b1};
                    st_nxt = S_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1;
                  end else begin
                    byte_nxt = '0;
                    if (count_r != '0) begin
                      shift_nxt = rd_data_r;
                      seg_nxt = SEG_TXDATA;
                      bit_nxt = 4'd0;
                      st_nxt = S_TX_SET; scl_nxt = 1'b0; sda_nxt = rd_data_r[7];
                    end else begin
                      st_nxt = S_STOP_P; scl_nxt = 1'b0; sda_nxt = 1'b0;
                    end
                  end
                end
                SEG_TXDATA: begin
                  byte_nxt = byte_inc;
                  if (byte_inc < count_r) begin
                    shift_nxt = rd_data_r;
                    bit_nxt = 4'd0;
                    st_nxt = S_TX_SET; scl_nxt = 1'b0; sda_nxt = rd_data_r[7];
                  end else begin
                    st_nxt = S_STOP_P; scl_nxt = 1'b0; sda_nxt = 1'b0;
                  end
                end
                SEG_ADDR_R: begin
                  byte_nxt = '0;
                  bit_nxt = 4'd0;
                  shift_nxt = 8'd0;
                  st_nxt = S_RX_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
                end
                default: ;
              endcase
            end
            S_RX_HIGH: begin
              shift_nxt = {shift_r[6:0], in_data.sda_in};
              st_nxt = S_RX_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1; phase_nxt = phase_load;
            end
            S_RX_LOW: begin
              bit_nxt = bit_inc;
              phase_nxt = phase_load;
              if (bit_inc < 4'd8) begin
                st_nxt = S_RX_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
              end else begin
                res.rx_valid = 1'b1;
                res.rx_byte  = shift_r;
                // nack on the last byte
                st_nxt = S_AO_SET; scl_nxt = 1'b0; sda_nxt = (byte_inc >= count_r);
              end
            end
            S_AO_SET: begin
              st_nxt = S_AO_HIGH; scl_nxt = 1'b1; phase_nxt = phase_load;
            end
            S_AO_HIGH: begin
              st_nxt = S_AO_LOW; scl_nxt = 1'b0; phase_nxt = phase_load;
            end
            S_AO_LOW: begin
              byte_nxt = byte_inc;
              phase_nxt = phase_load;
              if (byte_inc < count_r) begin
                bit_nxt = 4'd0;
                shift_nxt = 8'd0;
                st_nxt = S_RX_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1;
              end else begin
                st_nxt = S_STOP_P; scl_nxt = 1'b0; sda_nxt = 1'b0;
              end
            end
            S_STOP_P: begin
              st_nxt = S_STOP_A; scl_nxt = 1'b1; sda_nxt = 1'b0; phase_nxt = phase_load;
            end
            S_STOP_A: begin
              scl_nxt = 1'b1;
              sda_nxt = 1'b1;
              if (abort_r || read_r || settle_ticks_r == 16'd0) begin
                st_nxt        = S_IDLE;
                res.done_res  = 1'b1;
                res.ack_error = abort_r;
                if (!(abort_r || read_r)) begin
                  settle_nxt = settle_ticks_r;
                end
              end else begin
                settle_nxt = settle_ticks_r;
                st_nxt     = S_SETTLE;
              end
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      REQ_START: begin
        if (st_r == S_IDLE) begin
          slave_nxt    = in_data.slave_addr;
          regaddr_nxt  = in_data.reg_addr;
          read_nxt     = in_data.is_read;
          count_nxt    = cnt_sat;
          load_ptr_nxt = '0;
          abort_nxt    = 1'b0;
          seg_nxt      = SEG_ADDR_W;
          byte_nxt     = '0;
          shift_nxt    = {in_data.slave_addr, 1'b0};
          bit_nxt      = 4'd0;
          st_nxt = S_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = phase_load;
        end
      end
      REQ_LOAD: begin
        if (mem_we) begin
          load_ptr_nxt = load_ptr_r + CNT_W'(1);
        end
      end
      default: ;
    endcase

    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (st_nxt != S_IDLE);
  end

  // state registers advance only on a transfer into the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      seg_r      <= SEG_ADDR_W;
      phase_r    <= 16'd0;
      bit_r      <= 4'd0;
      byte_r     <= '0;
      shift_r    <= 8'd0;
      poll_r     <= 8'd0;
      settle_r   <= 16'd0;
      load_ptr_r <= '0;
      slave_r    <= 7'd0;
      regaddr_r  <= 8'd0;
      read_r     <= 1'b0;
      count_r    <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      abort_r    <= 1'b0;
    end else if (accept) begin
      st_r       <= st_nxt;
      seg_r      <= seg_nxt;
      phase_r    <= phase_nxt;
      bit_r      <= bit_nxt;
      byte_r     <= byte_nxt;
      shift_r    <= shift_nxt;
      poll_r     <= poll_nxt;
      settle_r   <= settle_nxt;
      load_ptr_r <= load_ptr_nxt;
      slave_r    <= slave_nxt;
      regaddr_r  <= regaddr_nxt;
      read_r     <= read_nxt;
      count_r    <= count_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      abort_r    <= abort_nxt;
    end
  end

  // result register: refilled on every accepted item, drained when not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

`ifndef ASSERT_OFF
  // a finished transfer reports idle in the same result
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done result still reports busy");

  // an abort flag only rides on the done pulse
  a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.ack_error |-> out_data_r.done_res)
    else $error("ack error without done");

  // during the settle wait the bus stays released
  a_settle_released: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_SETTLE |-> scl_r && sda_r)
    else $error("bus not released during settle");

  // buffer is never filled beyond its depth
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_ptr_r <= CNT_W'(MAX_BYTES))
    else $error("load pointer beyond buffer depth");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
  import i2cm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES = MAX_BYTES_DEF;
  // request code that the block must drop without spending bus time
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // quiet cycles (nothing moves on either side) before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // length of the long receiver hold-off used to back the block up
  localparam int HOLD_OFF_CYCLES = 64;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2c_register_master u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // bus sequencer model: register copies and sequencer state
  // ---------------------------------------------------------------------------
  logic [15:0] phase_cfg;
  logic [7:0]  poll_cfg;
  logic [15:0] settle_cfg;

  seq_state_t  bus_state;
  logic [15:0] slot_left;      // items left in the current timed slot
  logic [3:0]  bit_pos;
  logic [4:0]  byte_pos;
  logic [7:0]  shifter;
  logic [7:0]  poll_ticks;
  logic [15:0] settle_left;
  logic [7:0]  wr_buffer [MAX_BYTES];
  logic [4:0]  wr_fill;
  logic [6:0]  tgt_slave;
  logic [7:0]  tgt_reg;
  logic        tgt_read;
  logic [4:0]  tgt_count;
  logic        scl_q;
  logic        sda_q;
  seg_t        segment;
  logic        aborted;

  // per-item result flags
  logic        rx_strobe;
  logic [7:0]  rx_data;
  logic        done_strobe;
  logic        err_strobe;

  out_item_t expected_bus_out[$];
  int        fail_count = 0;
  bit        sender_gaps;
  bit        receiver_stalls;
  bit        hold_off_req = 1'b0;
  int        quiet_cycles = 0;

  function automatic void reset_model();
    phase_cfg   = PHASE_TICKS_RST;
    poll_cfg    = ACK_POLL_LIM_RST;
    settle_cfg  = SETTLE_TICKS_RST;
    bus_state   = S_IDLE;
    slot_left   = '0;
    bit_pos     = '0;
    byte_pos    = '0;
    shifter     = '0;
    poll_ticks  = '0;
    settle_left = '0;
    wr_fill     = '0;
    tgt_slave   = '0;
    tgt_reg     = '0;
    tgt_read    = 1'b0;
    tgt_count   = '0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    segment     = SEG_ADDR_W;
    aborted     = 1'b0;
  endfunction

  // every timed slot reloads its length; zero length acts as one
  function automatic void enter_slot(seq_state_t st, logic scl, logic sda);
    bus_state = st;
    scl_q     = scl;
    sda_q     = sda;
    slot_left = (phase_cfg == 16'd0) ? 16'd1 : phase_cfg;
  endfunction

  function automatic void begin_byte_out();
    bit_pos = '0;
    enter_slot(S_TX_SET, 1'b0, shifter[7]);
  endfunction

  function automatic void end_sequence();
    bus_state   = S_IDLE;
    done_strobe = 1'b1;
    err_strobe  = aborted;
  endfunction

  function automatic void next_write_byte();
    if (byte_pos < tgt_count && byte_pos < MAX_BYTES) begin
      shifter = wr_buffer[byte_pos[3:0]];
      segment = SEG_TXDATA;
      begin_byte_out();
    end else begin
      enter_slot(S_STOP_P, 1'b0, 1'b0);
    end
  endfunction

  // what happens when a timed slot runs out
  function automatic void slot_expired(logic sda);
    case (bus_state)
      S_ST_A:     enter_slot(S_ST_B, 1'b1, 1'b0);
      S_ST_B:     enter_slot(S_ST_C, 1'b0, 1'b0);
      S_ST_C:     begin_byte_out();
      S_TX_SET:   enter_slot(S_TX_HIGH, 1'b1, sda_q);
      S_TX_HIGH:  enter_slot(S_TX_LOW, 1'b0, sda_q);
      S_TX_LOW: begin
        bit_pos = bit_pos + 4'd1;
        if (bit_pos >= 4'd8) enter_slot(S_ACK_REL, 1'b0, 1'b1);
        else enter_slot(S_TX_SET, 1'b0, shifter[7 - int'(bit_pos)]);
      end
      S_ACK_REL:  enter_slot(S_ACK_HIGH, 1'b1, 1'b1);
      S_ACK_HIGH: begin
        poll_ticks = '0;
        bus_state  = S_ACK_POLL;
      end
      S_ACK_LOW: begin
        case (segment)
          SEG_ADDR_W: begin
            segment = SEG_SUBADDR;
            shifter = tgt_reg;
            begin_byte_out();
          end
          SEG_SUBADDR: begin
            if (tgt_read) begin
              // repeated start, then address with the read bit
              segment = SEG_ADDR_R;
              shifter = {tgt_slave, 1'b1};
              enter_slot(S_ST_A, 1'b1, 1'b1);
            end else begin
              byte_pos = '0;
              next_write_byte();
            end
          end
          SEG_TXDATA: begin
            byte_pos = byte_pos + 5'd1;
            next_write_byte();
          end
          default: begin
            byte_pos = '0;
            bit_pos  = '0;
            shifter  = '0;
            enter_slot(S_RX_HIGH, 1'b1, 1'b1);
          end
        endcase
      end
      S_RX_HIGH: begin
        shifter = {shifter[6:0], sda};
        enter_slot(S_RX_LOW, 1'b0, 1'b1);
      end
      S_RX_LOW: begin
        bit_pos = bit_pos + 4'd1;
        if (bit_pos < 4'd8) begin
          enter_slot(S_RX_HIGH, 1'b1, 1'b1);
        end else begin
          rx_strobe = 1'b1;
          rx_data   = shifter;
          // nack after the last byte, ack otherwise
          enter_slot(S_AO_SET, 1'b0, (int'(byte_pos) + 1 >= int'(tgt_count)));
        end
      end
      S_AO_SET:   enter_slot(S_AO_HIGH, 1'b1, sda_q);
      S_AO_HIGH:  enter_slot(S_AO_LOW, 1'b0, sda_q);
      S_AO_LOW: begin
        sda_q    = 1'b1;
        byte_pos = byte_pos + 5'd1;
        if (byte_pos < tgt_count) begin
          bit_pos = '0;
          shifter = '0;
          enter_slot(S_RX_HIGH, 1'b1, 1'b1);
        end else begin
          enter_slot(S_STOP_P, 1'b0, 1'b0);
        end
      end
      S_STOP_P:   enter_slot(S_STOP_A, 1'b1, 1'b0);
      S_STOP_A: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        if (aborted || tgt_read) begin
          end_sequence();
        end else begin
          settle_left = settle_cfg;
          if (settle_left == 16'd0) end_sequence();
          else bus_state = S_SETTLE;
        end
      end
      default:    bus_state = S_IDLE;
    endcase
  endfunction

  function automatic void bus_tick(logic sda);
    logic [7:0] limit;
    if (bus_state == S_IDLE) return;
    if (bus_state == S_SETTLE) begin
      if (settle_left != 16'd0) settle_left = settle_left - 16'd1;
      if (settle_left == 16'd0) end_sequence();
      return;
    end
    if (bus_state == S_ACK_POLL) begin
      if (!sda) begin
        enter_slot(S_ACK_LOW, 1'b0, 1'b1);
      end else begin
        limit      = (poll_cfg == 8'd0) ? 8'd1 : poll_cfg;
        poll_ticks = poll_ticks + 8'd1;
        if (poll_ticks >= limit) begin
          aborted = 1'b1;
          enter_slot(S_STOP_P, 1'b0, 1'b0);
        end
      end
      return;
    end
    if (slot_left > 16'd1) begin
      slot_left = slot_left - 16'd1;
      return;
    end
    slot_left = '0;
    slot_expired(sda);
  endfunction

  // expected output for one accepted request
  function automatic out_item_t predict_bus_item(in_item_t item);
    out_item_t  res;
    logic [4:0] count;
    rx_strobe   = 1'b0;
    rx_data     = '0;
    done_strobe = 1'b0;
    err_strobe  = 1'b0;
    case (item.req_type)
      REQ_TICK: bus_tick(item.sda_in);
      REQ_START: begin
        if (bus_state == S_IDLE) begin
          count     = item.byte_count;
          tgt_slave = item.slave_addr;
          tgt_reg   = item.reg_addr;
          tgt_read  = item.is_read;
          if (tgt_read && count == 5'd0) count = 5'd1;
          if (count > MAX_BYTES) count = 5'(MAX_BYTES);
          tgt_count = count;
          wr_fill   = '0;
          aborted   = 1'b0;
          segment   = SEG_ADDR_W;
          byte_pos  = '0;
          shifter   = {item.slave_addr, 1'b0};
          bit_pos   = '0;
          enter_slot(S_ST_A, 1'b1, 1'b1);
        end
      end
      REQ_LOAD: begin
        if (bus_state == S_IDLE && wr_fill < MAX_BYTES) begin
          wr_buffer[wr_fill[3:0]] = item.tx_byte;
          wr_fill = wr_fill + 5'd1;
        end
      end
      default: ;
    endcase
    res.scl_out   = scl_q;
    res.sda_out   = sda_q;
    res.busy_res  = (bus_state != S_IDLE);
    res.rx_valid  = rx_strobe;
    res.rx_byte   = rx_data;
    res.done_res  = done_strobe;
    res.ack_error = err_strobe;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts plus an on-demand long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // long hold so the output register fills and the input backs up
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(string tag, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, tag, want, got);
      fail_count++;
    end
  endfunction

  // compare each accepted result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bus_out.size() == 0) begin
        $display("%0t ns: result transfer with nothing expected, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = expected_bus_out.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(out_data.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("rx_valid", 8'(want.rx_valid), 8'(out_data.rx_valid));
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        check_field("ack_error", 8'(want.ack_error), 8'(out_data.ack_error));
      end
    end
  end

  // hang detection: count cycles in which no transfer happens on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side helpers; every task returns at a falling edge
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(req_t kind);
    in_item_t item;
    item.req_type   = kind;
    item.sda_in     = 1'($urandom);
    item.slave_addr = 7'($urandom);
    item.reg_addr   = 8'($urandom);
    item.is_read    = 1'($urandom);
    item.byte_count = 5'($urandom);
    item.tx_byte    = 8'($urandom);
    return item;
  endfunction

  task automatic send_item(in_item_t item);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // hold the payload until the transfer goes through
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_bus_out.push_back(predict_bus_item(item));
    @(negedge clk);
  endtask

  // stop offering requests and wait for every expected result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_bus_out.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_PHASE_TICKS:  phase_cfg = value;
      CFG_ACK_POLL_LIM: poll_cfg = value[7:0];
      CFG_SETTLE_TICKS: settle_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_byte(logic [7:0] value);
    in_item_t item;
    item         = make_item(REQ_LOAD);
    item.tx_byte = value;
    send_item(item);
  endtask

  task automatic issue_start(logic [6:0] slave, logic [7:0] subaddr, logic rd,
                             logic [4:0] count);
    in_item_t item;
    item            = make_item(REQ_START);
    item.slave_addr = slave;
    item.reg_addr   = subaddr;
    item.is_read    = rd;
    item.byte_count = count;
    send_item(item);
  endtask

  // one tick; during an ack poll the slave acks with the given odds while
  // it still has acks to give, otherwise sda is random (read data, noise)
  task automatic tick_bus(int ack_pct, inout int acks_left);
    in_item_t item;
    item = make_item(REQ_TICK);
    if (bus_state == S_ACK_POLL) begin
      if (acks_left > 0 && $urandom_range(0, 99) < ack_pct) begin
        item.sda_in = 1'b0;
        acks_left--;
      end else begin
        item.sda_in = 1'b1;
      end
    end
    send_item(item);
  endtask

  task automatic run_to_idle(int ack_pct, int acks);
    int acks_left;
    acks_left = acks;
    while (bus_state != S_IDLE) tick_bus(ack_pct, acks_left);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset slot length and poll limit; buffer fill and overflow, dropped requests
  task automatic test_reset_defaults();
    int acks_left;
    acks_left = 0;
    // seventeen loads: the last one finds the buffer full
    load_byte(8'h00);
    load_byte(8'hFF);
    for (int i = 2; i <= MAX_BYTES; i++) load_byte(8'($urandom));
    send_item(make_item(req_t'(REQ_UNUSED)));
    send_item(make_item(REQ_TICK));
    issue_start(7'h7F, 8'h00, 1'b0, 5'd2);
    repeat (3) tick_bus(100, acks_left);
    // start, load and the unused code are all dropped while busy
    send_item(make_item(REQ_START));
    send_item(make_item(REQ_LOAD));
    send_item(make_item(req_t'(REQ_UNUSED)));
    // rest of the start condition at the reset slot length, then short slots
    repeat (9) tick_bus(100, acks_left);
    write_reg(CFG_PHASE_TICKS, 16'd1);
    // the slave never acks: the reset poll limit ends the transfer
    run_to_idle(100, 0);
  endtask

  // read of zero bytes acts as one
  task automatic test_read_counts();
    write_reg(CFG_PHASE_TICKS, 16'd1);
    write_reg(CFG_ACK_POLL_LIM, 16'd255);
    write_reg(CFG_SETTLE_TICKS, 16'd0);
    issue_start(7'h00, 8'hFF, 1'b1, 5'd0);
    run_to_idle(100, 1000);
  endtask

  // zero phase length, zero-byte write, pointer cleared by start
  task automatic test_write_counts();
    write_reg(CFG_PHASE_TICKS, 16'd0);
    issue_start(7'($urandom), 8'($urandom), 1'b0, 5'd0);
    run_to_idle(100, 1000);
    write_reg(CFG_SETTLE_TICKS, 16'd1);
    repeat (2) load_byte(8'($urandom));
    issue_start(7'($urandom), 8'($urandom), 1'b0, 5'd2);
    run_to_idle(100, 1000);
  endtask

  // missing acks at several points of the sequence, with several poll limits
  task automatic test_ack_timeouts();
    write_reg(CFG_ACK_POLL_LIM, 16'd0);
    issue_start(7'($urandom), 8'($urandom), 1'b0, 5'd1);
    run_to_idle(100, 0);
    write_reg(CFG_ACK_POLL_LIM, 16'd1);
    issue_start(7'($urandom), 8'($urandom), 1'b1, 5'd2);
    run_to_idle(100, 2);
    // an aborted write skips the settle wait, however long
    write_reg(CFG_SETTLE_TICKS, 16'hFFFF);
    write_reg(CFG_ACK_POLL_LIM, 16'd3);
    issue_start(7'($urandom), 8'($urandom), 1'b0, 5'd1);
    run_to_idle(100, 2);
  endtask

  // receiver holds off while requests keep coming, then the sender waits
  task automatic test_backpressure();
    int acks_left;
    acks_left = 1000;
    write_reg(CFG_PHASE_TICKS, 16'd1);
    write_reg(CFG_ACK_POLL_LIM, 16'd8);
    write_reg(CFG_SETTLE_TICKS, 16'd10);
    issue_start(7'($urandom), 8'($urandom), 1'b1, 5'd1);
    repeat (10) tick_bus(100, acks_left);
    hold_off_req = 1'b1;
    repeat (40) tick_bus(100, acks_left);
    drain_results();
    run_to_idle(100, acks_left);
  endtask

  // mostly well-formed bus sequences with random content, plus dropped noise
  task automatic random_round(int budget);
    int       counted;
    int       acks_left;
    in_item_t item;
    logic [4:0] count;
    counted   = 0;
    acks_left = 1 << 30;
    while (counted < budget) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise the block must drop; not counted
        if (bus_state == S_IDLE) begin
          item = make_item($urandom_range(0, 1) ? REQ_TICK : req_t'(REQ_UNUSED));
        end else begin
          case ($urandom_range(0, 2))
            0:       item = make_item(REQ_START);
            1:       item = make_item(REQ_LOAD);
            default: item = make_item(req_t'(REQ_UNUSED));
          endcase
        end
        send_item(item);
      end else if (bus_state == S_IDLE) begin
        if ($urandom_range(0, 19) < 7 && wr_fill < MAX_BYTES) begin
          load_byte(8'($urandom));
        end else begin
          count = 5'($urandom_range(0, 3));
          issue_start(7'($urandom), 8'($urandom), 1'($urandom), count);
        end
        counted++;
      end else begin
        tick_bus(85, acks_left);
        counted++;
      end
    end
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      run_to_idle(100, 1000);
      write_reg(CFG_PHASE_TICKS, 16'($urandom_range(0, 1)));
      write_reg(CFG_ACK_POLL_LIM, 16'($urandom_range(0, 6)));
      write_reg(CFG_SETTLE_TICKS, 16'($urandom_range(0, 8)));
      random_round(35);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_to_idle(100, 1000);
    write_reg(CFG_PHASE_TICKS, 16'd1);
    write_reg(CFG_ACK_POLL_LIM, 16'd4);
    write_reg(CFG_SETTLE_TICKS, 16'd3);
    load_byte(8'($urandom));
    issue_start(7'($urandom), 8'($urandom), 1'b0, 5'd1);
    run_to_idle(100, 1000);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_PHASE_TICKS;
    cfg_wdata       = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    reset_model();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_read_counts();
    test_write_counts();
    test_ack_timeouts();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();

    // wait out the last results and any strays
    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
